[hdl/pnm_pkg.sv]
// Shared types, constants and helpers for the PNM sample to RGBA8 converter.
// Depends on nothing; every module in hdl/ imports it.
package pnm_pkg;

    localparam int CHAN_W          = 16;   // width of one input sample field
    localparam int OUT_W           = 8;    // width of one output channel
    localparam int MAX_W           = 16;   // width of maxval
    localparam int QUO_BITS        = 8;    // quotient bits, one per divider cell
    localparam int LANES           = 4;    // red, green, blue, alpha
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic [OUT_W-1:0] FULL8 = 8'hFF;
    localparam logic [OUT_W-1:0] ZERO8 = 8'h00;

    typedef enum logic [1:0] {
        FMT_BITMAP = 2'd0,
        FMT_GRAY   = 2'd1,
        FMT_RGB    = 2'd2,
        FMT_RGBA   = 2'd3
    } pix_fmt_t;

    // register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_FORMAT = 1'b0,
        REG_MAX    = 1'b1
    } reg_idx_t;

    localparam pix_fmt_t          FORMAT_RST = FMT_RGB;
    localparam logic [MAX_W-1:0]  MAX_RST    = 16'd255;

    typedef enum logic [1:0] {
        LANE_DIV  = 2'd0,    // result comes from the divider
        LANE_ZERO = 2'd1,    // forced 0
        LANE_FULL = 2'd2     // forced 255
    } lane_mode_t;

    typedef struct packed {
        lane_mode_t          mode;
        logic [MAX_W-1:0]    rem;   // partial remainder, below maxval in a lane that divides
        logic [QUO_BITS-1:0] low;   // dividend bits not yet brought down
        logic [QUO_BITS-1:0] quo;   // quotient bits produced so far
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0] lanes;
        logic              over;
    } cell_word_t;

    function automatic logic [OUT_W-1:0] lane_value(lane_t l);
        logic [OUT_W-1:0] v;
        v = l.quo;
        unique case (l.mode)
            LANE_ZERO: v = ZERO8;
            LANE_FULL: v = FULL8;
            default:   v = l.quo;
        endcase
        return v;
    endfunction

endpackage

[hdl/pnm_prep.sv]
// Entry stage: masks samples, picks lanes by pixel format, checks range and
// forms the v*255 dividend for the divider chain. Uses pnm_pkg.
module pnm_prep #(
    parameter int SAMPLE_BITS = pnm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         in_valid,
    input  logic [pnm_pkg::CHAN_W-1:0]   chan0,
    input  logic [pnm_pkg::CHAN_W-1:0]   chan1,
    input  logic [pnm_pkg::CHAN_W-1:0]   chan2,
    input  logic [pnm_pkg::CHAN_W-1:0]   chan3,
    input  pnm_pkg::pix_fmt_t            pixel_format,
    input  logic [pnm_pkg::MAX_W-1:0]    maxval,
    output logic                         out_valid,
    output pnm_pkg::cell_word_t          out_word
);
    import pnm_pkg::*;

    localparam logic [CHAN_W-1:0] SAMPLE_MASK = CHAN_W'((33'd1 << SAMPLE_BITS) - 33'd1);

    logic       valid_reg;
    cell_word_t word_reg;
    cell_word_t word_next;
    lane_t      l0;
    lane_t      l1;
    lane_t      l2;
    lane_t      l3;
    logic       o0;
    logic       o1;
    logic       o2;
    logic       o3;

    function automatic lane_t scale_lane(logic [CHAN_W-1:0] raw, logic [MAX_W-1:0] mx,
                                         output logic over);
        lane_t                      l;
        logic [CHAN_W-1:0]          s;
        logic [CHAN_W+OUT_W-1:0]    prod;
        s    = raw & SAMPLE_MASK;
        prod = {s, 8'h00} - {8'h00, s};   // s * 255
        over = (s > mx);
        l.rem  = MAX_W'(prod[CHAN_W+OUT_W-1:OUT_W]);
        l.low  = prod[QUO_BITS-1:0];
        l.quo  = '0;
        if (over)
            l.mode = LANE_FULL;
        else if (s == '0)
            l.mode = LANE_ZERO;       // also covers maxval of zero
        else
            l.mode = LANE_DIV;
        return l;
    endfunction

    always_comb
    begin
        l0 = scale_lane(chan0, maxval, o0);
        l1 = scale_lane(chan1, maxval, o1);
        l2 = scale_lane(chan2, maxval, o2);
        l3 = scale_lane(chan3, maxval, o3);
        word_next.lanes[3]          = l3;
        word_next.lanes[3].mode     = LANE_FULL;
        word_next.over              = 1'b0;
        unique case (pixel_format)
            FMT_BITMAP:
            begin
                word_next.lanes[0]      = l0;
                word_next.lanes[0].mode = chan0[0] ? LANE_ZERO : LANE_FULL;
                word_next.lanes[1]      = word_next.lanes[0];
                word_next.lanes[2]      = word_next.lanes[0];
            end
            FMT_GRAY:
            begin
                word_next.lanes[0] = l0;
                word_next.lanes[1] = l0;
                word_next.lanes[2] = l0;
                word_next.over     = o0;
            end
            FMT_RGB:
            begin
                word_next.lanes[0] = l0;
                word_next.lanes[1] = l1;
                word_next.lanes[2] = l2;
                word_next.over     = o0 | o1 | o2;
            end
            default:
            begin
                word_next.lanes[0] = l0;
                word_next.lanes[1] = l1;
                word_next.lanes[2] = l2;
                word_next.lanes[3] = l3;
                word_next.over     = o0 | o1 | o2 | o3;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

[hdl/pnm_div_cell.sv]
// One cell of the divider chain: brings down one dividend bit and makes one
// quotient bit in each of the four lanes. Uses pnm_pkg.
module pnm_div_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        in_valid,
    input  pnm_pkg::cell_word_t         in_word,
    input  logic [pnm_pkg::MAX_W-1:0]   divisor,
    output logic                        out_valid,
    output pnm_pkg::cell_word_t         out_word
);
    import pnm_pkg::*;

    logic       valid_reg;
    cell_word_t word_reg;
    cell_word_t word_next;

    always_comb
    begin
        logic [MAX_W:0] trial;
        logic [MAX_W:0] diff;
        logic           take;
        word_next = in_word;
        for (int i = 0; i < LANES; i++)
        begin
            trial = {in_word.lanes[i].rem, in_word.lanes[i].low[QUO_BITS-1]};
            diff  = trial - {1'b0, divisor};
            take  = (trial >= {1'b0, divisor});
            word_next.lanes[i].rem = take ? diff[MAX_W-1:0] : trial[MAX_W-1:0];
            word_next.lanes[i].low = {in_word.lanes[i].low[QUO_BITS-2:0], 1'b0};
            word_next.lanes[i].quo = {in_word.lanes[i].quo[QUO_BITS-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

[hdl/pnm_sample_to_rgba8.sv]
// Top level of the PNM sample to RGBA8 converter: APB registers, entry stage,
// divider cell chain and output register. Uses pnm_pkg, pnm_prep, pnm_div_cell.
//
// Takes one PNM pixel per clock and gives one 8-bit RGBA word per clock while
// out_ready stays high, in order, through one entry stage, eight divider cells
// (one quotient bit of floor(v*255/maxval) each) and the output register.
// Each stage moves on whenever the one after it is empty or moving, so gaps
// close up under output back-pressure and in_ready stays high while any
// stage has room. Outside bitmap, samples above maxval give 255 and set over_range.
// Write pixel_format (0x0) and maxval (0x4) only while the block is idle.
module pnm_sample_to_rgba8 #(
    parameter int SAMPLE_BITS = pnm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pnm_pkg::CHAN_W-1:0]    chan0,
    input  logic [pnm_pkg::CHAN_W-1:0]    chan1,
    input  logic [pnm_pkg::CHAN_W-1:0]    chan2,
    input  logic [pnm_pkg::CHAN_W-1:0]    chan3,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pnm_pkg::OUT_W-1:0]     red,
    output logic [pnm_pkg::OUT_W-1:0]     green,
    output logic [pnm_pkg::OUT_W-1:0]     blue,
    output logic [pnm_pkg::OUT_W-1:0]     alpha,
    output logic                          over_range,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pnm_pkg::PADDR_W-1:0]   paddr,
    input  logic [pnm_pkg::PDATA_W-1:0]   pwdata,
    output logic [pnm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import pnm_pkg::*;

    pix_fmt_t          pixel_format_reg;
    logic [MAX_W-1:0]  maxval_reg;
    reg_idx_t          reg_idx;
    logic              cfg_write;

    logic              link_valid [0:QUO_BITS];
    cell_word_t        link_word  [0:QUO_BITS];
    logic [QUO_BITS:0] adv;
    logic              prep_adv;

    logic              out_valid_reg;
    logic [OUT_W-1:0]  red_reg;
    logic [OUT_W-1:0]  green_reg;
    logic [OUT_W-1:0]  blue_reg;
    logic [OUT_W-1:0]  alpha_reg;
    logic              over_reg;

    // ---- configuration port
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= FORMAT_RST;
            maxval_reg       <= MAX_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_FORMAT: pixel_format_reg <= pix_fmt_t'(pwdata[1:0]);
                REG_MAX:    maxval_reg       <= pwdata[MAX_W-1:0];
                default:    maxval_reg       <= maxval_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FORMAT: prdata = {{(PDATA_W-2){1'b0}}, pixel_format_reg};
            REG_MAX:    prdata = {{(PDATA_W-MAX_W){1'b0}}, maxval_reg};
            default:    prdata = '0;
        endcase
    end

    // ---- stage enables: a stage moves when the next one is empty or moving
    always_comb
    begin
        adv[QUO_BITS] = !out_valid_reg || out_ready;
        for (int k = QUO_BITS - 1; k >= 0; k--)
            adv[k] = !link_valid[k+1] || adv[k+1];
        prep_adv = !link_valid[0] || adv[0];
    end

    assign in_ready = prep_adv;

    pnm_prep #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (prep_adv),
        .in_valid     (in_valid),
        .chan0        (chan0),
        .chan1        (chan1),
        .chan2        (chan2),
        .chan3        (chan3),
        .pixel_format (pixel_format_reg),
        .maxval       (maxval_reg),
        .out_valid    (link_valid[0]),
        .out_word     (link_word[0])
    );

    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_cell
        pnm_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (adv[k]),
            .in_valid  (link_valid[k]),
            .in_word   (link_word[k]),
            .divisor   (maxval_reg),
            .out_valid (link_valid[k+1]),
            .out_word  (link_word[k+1])
        );
    end

    // ---- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv[QUO_BITS])
            out_valid_reg <= link_valid[QUO_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (adv[QUO_BITS] && link_valid[QUO_BITS])
        begin
            red_reg   <= lane_value(link_word[QUO_BITS].lanes[0]);
            green_reg <= lane_value(link_word[QUO_BITS].lanes[1]);
            blue_reg  <= lane_value(link_word[QUO_BITS].lanes[2]);
            alpha_reg <= lane_value(link_word[QUO_BITS].lanes[3]);
            over_reg  <= link_word[QUO_BITS].over;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign alpha      = alpha_reg;
    assign over_range = over_reg;

    // ---- assertions
    a_accept_fills_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> link_valid[0])
        else $error("accepted word did not reach entry stage");

    a_bitmap_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_format_reg == FMT_BITMAP |->
            !over_range && red == green && green == blue && alpha == FULL8)
        else $error("bitmap word malformed");

    a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_format_reg == FMT_GRAY |-> red == green && green == blue)
        else $error("gray word channels differ");

    a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_format_reg != FMT_RGBA |-> alpha == FULL8)
        else $error("alpha not opaque outside rgba");

endmodule

[test/tb.sv]
// Self-checking testbench for pnm_sample_to_rgba8: directed and random pixels under
// several configurations and idle patterns, checked against an in-bench pixel model.
// Depends on pnm_pkg and the pnm_sample_to_rgba8 RTL.
`timescale 1ns / 100ps

module tb;
    import pnm_pkg::*;

    localparam int QUIET_LIMIT = 4000;   // cycles with no word moving before giving up
    localparam int TAIL_CYCLES = 20;     // pipeline is 10 deep
    localparam int SEGMENTS    = 12;
    localparam int SEG_WORDS   = 75;
    localparam int MAX_SHOWN   = 60;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
        logic [OUT_W-1:0] alpha;
        logic             over;
    } rgba_t;

    class rgba_checker;
        pix_fmt_t         fmt;
        logic [MAX_W-1:0] maxv;
        rgba_t            pending_rgba[$];
        int               errs;
        int               shown;

        function new();
            fmt   = FORMAT_RST;
            maxv  = MAX_RST;
            errs  = 0;
            shown = 0;
        endfunction

        function logic [OUT_W-1:0] scale_chan(logic [CHAN_W-1:0] v, inout bit ovf);
            int unsigned prod;
            if (v > maxv) begin
                ovf = 1'b1;
                return FULL8;
            end
            if (maxv == 0)
                return ZERO8;
            prod = int'(v) * 255;
            return OUT_W'(prod / int'(maxv));
        endfunction

        function rgba_t to_rgba8(logic [CHAN_W-1:0] c0, logic [CHAN_W-1:0] c1,
                                 logic [CHAN_W-1:0] c2, logic [CHAN_W-1:0] c3);
            rgba_t p;
            bit    ovf;
            ovf     = 1'b0;
            p.alpha = FULL8;
            case (fmt)
                FMT_BITMAP:
                begin
                    p.red = c0[0] ? ZERO8 : FULL8;
                    p.green = p.red;
                    p.blue = p.red;
                end
                FMT_GRAY:
                begin
                    p.red = scale_chan(c0, ovf);
                    p.green = p.red;
                    p.blue = p.red;
                end
                FMT_RGB:
                begin
                    p.red = scale_chan(c0, ovf);
                    p.green = scale_chan(c1, ovf);
                    p.blue = scale_chan(c2, ovf);
                end
                default:
                begin
                    p.red = scale_chan(c0, ovf);
                    p.green = scale_chan(c1, ovf);
                    p.blue = scale_chan(c2, ovf);
                    p.alpha = scale_chan(c3, ovf);
                end
            endcase
            p.over = ovf;
            return p;
        endfunction

        function void note_pixel(logic [CHAN_W-1:0] c0, logic [CHAN_W-1:0] c1,
                                 logic [CHAN_W-1:0] c2, logic [CHAN_W-1:0] c3);
            pending_rgba.push_back(to_rgba8(c0, c1, c2, c3));
        endfunction

        function void flag_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
            if (want !== got) begin
                errs++;
                if (shown < MAX_SHOWN) begin
                    shown++;
                    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                end
            end
        endfunction

        function void check_pixel(rgba_t got);
            rgba_t want;
            if (pending_rgba.size() == 0) begin
                errs++;
                $display("%0t: output word with nothing pending, actual %h", $time, got);
                return;
            end
            want = pending_rgba.pop_front();
            flag_field("red", want.red, got.red);
            flag_field("green", want.green, got.green);
            flag_field("blue", want.blue, got.blue);
            flag_field("alpha", want.alpha, got.alpha);
            flag_field("over_range", {7'd0, want.over}, {7'd0, got.over});
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [CHAN_W-1:0]    chan0, chan1, chan2, chan3;
    logic                 out_valid;
    logic                 out_ready;
    logic [OUT_W-1:0]     red, green, blue, alpha;
    logic                 over_range;
    logic                 psel, penable, pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    rgba_checker sb;
    int          send_pct;
    int          stall_pct;
    int          quiet;

    pnm_sample_to_rgba8 dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .chan0(chan0), .chan1(chan1), .chan2(chan2), .chan3(chan3),
        .out_valid(out_valid), .out_ready(out_ready),
        .red(red), .green(green), .blue(blue), .alpha(alpha), .over_range(over_range),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receive side: check accepted words, then draw the next ready
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_pixel('{red, green, blue, alpha, over_range});
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet <= 0;
        end
        else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("pnm_sample_to_rgba8 verification failed");
                $finish;
            end
        end
    end

    task automatic send_pixel(logic [CHAN_W-1:0] c0, logic [CHAN_W-1:0] c1,
                              logic [CHAN_W-1:0] c2, logic [CHAN_W-1:0] c3);
        while ($urandom_range(99) < send_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        chan0 <= c0;
        chan1 <= c1;
        chan2 <= c2;
        chan3 <= c3;
        do @(posedge clk); while (!in_ready);
        sb.note_pixel(c0, c1, c2, c3);
    endtask

    // drop valid and wait until every pending word has come out
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (sb.pending_rgba.size() != 0)
            @(posedge clk);
    endtask

    // write, then read back; called only with the pipe empty
    task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] val);
        logic [PDATA_W-1:0] rd;
        logic [PDATA_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (idx == REG_FORMAT) begin
            sb.fmt = pix_fmt_t'(val[1:0]);
            want = {30'd0, val[1:0]};
        end
        else begin
            sb.maxv = val[MAX_W-1:0];
            want = {16'd0, val[MAX_W-1:0]};
        end
        if (rd !== want) begin
            sb.errs++;
            $display("%0t: register %0d readback, expected %h, actual %h", $time, idx, want, rd);
        end
    endtask

    task automatic set_config(pix_fmt_t f, logic [MAX_W-1:0] m);
        drain_pipe();
        write_reg(REG_FORMAT, {30'd0, f});
        write_reg(REG_MAX, {16'd0, m});
    endtask

    // samples biased toward the saturation edge
    function automatic logic [CHAN_W-1:0] pick_sample(logic [MAX_W-1:0] m);
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2, 3: return CHAN_W'($urandom_range(int'(m), 0));
            4: return m;
            5: return m + 1'b1;
            6: return m - 1'b1;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int               phase;
        pix_fmt_t         f;
        logic [MAX_W-1:0] m;
        logic [MAX_W-1:0] seg_max [SEGMENTS];

        sb = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        chan0     <= '0;
        chan1     <= '0;
        chan2     <= '0;
        chan3     <= '0;
        out_ready <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        send_pct  <= 0;
        stall_pct <= 0;
        quiet     <= 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: rgb, max 255
        send_pixel(16'd0, 16'd0, 16'd0, 16'd0);
        send_pixel(16'd255, 16'd254, 16'd256, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'd128, 16'd1, 16'd0, 16'd999);

        set_config(FMT_BITMAP, 16'd255);
        send_pixel(16'd1, 16'd0, 16'd0, 16'd0);
        send_pixel(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFE, 16'd0, 16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'd0, 16'd0, 16'd0);

        set_config(FMT_GRAY, 16'hFFFF);
        send_pixel(16'hFFFF, 16'd0, 16'd0, 16'd0);
        send_pixel(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h8000, 16'hFFFF, 16'd0, 16'd0);

        set_config(FMT_RGBA, 16'd1);
        send_pixel(16'd0, 16'd1, 16'd2, 16'd1);
        send_pixel(16'd1, 16'd1, 16'd1, 16'd2);
        send_pixel(16'd0, 16'd0, 16'd0, 16'd0);

        // zero maxval: only a zero sample stays in range
        set_config(FMT_RGBA, 16'd0);
        send_pixel(16'd0, 16'd0, 16'd1, 16'd0);
        send_pixel(16'd0, 16'd0, 16'd0, 16'd0);
        send_pixel(16'd0, 16'd0, 16'd0, 16'hFFFF);

        set_config(FMT_GRAY, 16'd0);
        send_pixel(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'd1, 16'd0, 16'd0, 16'd0);

        set_config(FMT_RGB, 16'd1000);
        send_pixel(16'd999, 16'd1000, 16'd1001, 16'hFFFF);
        send_pixel(16'd500, 16'd3, 16'd0, 16'd0);

        seg_max = '{16'd255, 16'hFFFF, 16'd1, 16'd0, 16'd1000, 16'd3,
                    16'd255, 16'hFFFF, 16'd2, 16'd7, 16'd4095, 16'd255};
        seg_max[6]  = MAX_W'($urandom_range(65535, 1));
        seg_max[10] = MAX_W'($urandom_range(65535, 0));

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            f = pix_fmt_t'(seg % 4);
            m = seg_max[seg];
            set_config(f, m);
            phase = seg / 3;
            case (phase)
                0: begin send_pct <= 0;  stall_pct <= 0;  end
                1: begin send_pct <= 59; stall_pct <= 0;  end
                2: begin send_pct <= 0;  stall_pct <= 59; end
                default: begin send_pct <= 10; stall_pct <= 10; end
            endcase
            for (int n = 0; n < SEG_WORDS; n++) begin
                if (seg == 5 && n == 37)
                    drain_pipe();
                send_pixel(pick_sample(m), pick_sample(m), pick_sample(m), pick_sample(m));
            end
        end

        drain_pipe();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errs == 0 && sb.pending_rgba.size() == 0)
            $display("pnm_sample_to_rgba8 verification clean");
        else
            $display("pnm_sample_to_rgba8 verification failed");
        $finish;
    end

endmodule
